FILE: rtl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8sd_pkg;

	localparam int unsigned CpW   = 21;
	localparam int unsigned UsedW = 3;

	localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CpW-1:0] MIN_CP_LEN2    = 21'h000080;
	localparam logic [CpW-1:0] MIN_CP_LEN3    = 21'h000800;
	localparam logic [CpW-1:0] MIN_CP_LEN4    = 21'h010000;
	localparam logic [CpW-1:0] MAX_CP         = 21'h10FFFF;

	localparam logic [7:0] LEAD2_BASE = 8'hC0;
	localparam logic [7:0] LEAD3_BASE = 8'hE0;
	localparam logic [7:0] LEAD4_BASE = 8'hF0;
	localparam logic [7:0] LEAD_LIMIT = 8'hF5;
	localparam logic [7:0] CONT_BASE  = 8'h80;

	localparam logic [UsedW-1:0] SEQ_LEN1 = 3'd1;
	localparam logic [UsedW-1:0] SEQ_LEN2 = 3'd2;
	localparam logic [UsedW-1:0] SEQ_LEN3 = 3'd3;
	localparam logic [UsedW-1:0] SEQ_LEN4 = 3'd4;

	typedef struct packed {
		logic [CpW-1:0]   code_point;
		logic             is_valid;
		logic [UsedW-1:0] bytes_used;
		logic             run_last;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/u8sd_in_if.sv
// Byte channel into the UTF-8 stream decoder.
`default_nettype none

interface u8sd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_end;

	modport source (output valid, output in_byte, output stream_end, input ready);
	modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/u8sd_out_if.sv
// Code point channel out of the UTF-8 stream decoder.
`default_nettype none

interface u8sd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        is_valid;
	logic [2:0]  bytes_used;
	logic        run_last;

	modport source (output valid, output code_point, output is_valid, output bytes_used,
		output run_last, input ready);
	modport sink   (input valid, input code_point, input is_valid, input bytes_used,
		input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: bytes in, code points with status out.
//
// The stream channel takes one raw byte per beat together with a stream_end
// flag on the last byte of a stream. The result channel returns decoded code
// points; each beat carries the scalar value (U+FFFD on any error), an
// is_valid flag, the number of stream bytes the result covers and run_last,
// which marks the final result caused by one input byte.
// The results of an accepted byte are registered and appear on the result
// channel in the next cycle. Lead and middle bytes of a sequence give no
// result unless they carry stream_end. Throughput is one byte per cycle as
// long as each byte gives at most one result and the receiver does not stall.
// A byte that breaks an open sequence gives two results, unless it opens a
// new sequence itself; the two results leave one after the other.
// The result register holds up to two results. A new byte is taken when the
// register is empty, or when it holds one result that leaves in the same
// cycle. When the receiver stalls, results wait in the register and the
// stream channel stalls with it; nothing is lost or repeated.
// Reset clears the open sequence and empties the result register.
`default_nettype none

module utf8_stream_decoder_top
	import u8sd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	u8sd_in_if.sink     stream,
	u8sd_out_if.source  result
);

	// Open sequence state.
	logic [1:0]       held_q;
	logic [UsedW-1:0] exp_q;
	logic [CpW-1:0]   part_q;

	// Result register: up to two results, oldest in slot 0.
	result_t    res0_s1;
	result_t    res1_s1;
	logic [1:0] cnt_s1;

	logic accept;
	logic out_fire;

	// Decode of the byte as a fresh lead.
	logic             st_emit;
	result_t          st_res;
	logic [UsedW-1:0] st_len;
	logic [CpW-1:0]   st_bits;

	// Results of this byte and the next sequence state.
	result_t          r0;
	result_t          r1;
	logic [1:0]       n_res;
	logic [1:0]       held_d;
	logic [UsedW-1:0] exp_d;
	logic [CpW-1:0]   part_d;

	logic [UsedW-1:0] cnt_inc;
	logic [CpW-1:0]   v_cat;
	logic             is_cont;
	logic             in_rng;

	assign out_fire     = result.valid && result.ready;
	assign stream.ready = (cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && result.ready);
	assign accept       = stream.valid && stream.ready;

	always_comb begin
		st_emit = 1'b1;
		st_len  = SEQ_LEN1;
		st_bits = '0;
		st_res  = '{code_point: REPLACEMENT_CP, is_valid: 1'b0, bytes_used: SEQ_LEN1,
			run_last: 1'b0};
		if (stream.in_byte < CONT_BASE) begin
			st_res.code_point = {13'd0, stream.in_byte};
			st_res.is_valid   = 1'b1;
		end else if (stream.in_byte < LEAD2_BASE || stream.in_byte >= LEAD_LIMIT) begin
			st_emit = 1'b1;
		end else begin
			if (stream.in_byte < LEAD3_BASE) begin
				st_len  = SEQ_LEN2;
				st_bits = {16'd0, stream.in_byte[4:0]};
			end else if (stream.in_byte < LEAD4_BASE) begin
				st_len  = SEQ_LEN3;
				st_bits = {17'd0, stream.in_byte[3:0]};
			end else begin
				st_len  = SEQ_LEN4;
				st_bits = {18'd0, stream.in_byte[2:0]};
			end
			// A lead on the last byte is cut off at once.
			st_emit = stream.stream_end;
		end
	end

	assign is_cont = (stream.in_byte[7:6] == 2'b10);
	assign cnt_inc = {1'b0, held_q} + SEQ_LEN1;
	assign v_cat   = {part_q[CpW-7:0], stream.in_byte[5:0]};

	always_comb begin
		case (exp_q)
			SEQ_LEN2: in_rng = (v_cat >= MIN_CP_LEN2);
			SEQ_LEN3: in_rng = (v_cat >= MIN_CP_LEN3);
			default:  in_rng = (v_cat >= MIN_CP_LEN4) && (v_cat <= MAX_CP);
		endcase
	end

	always_comb begin
		r0     = '{code_point: REPLACEMENT_CP, is_valid: 1'b0, bytes_used: cnt_inc,
			run_last: 1'b1};
		r1     = st_res;
		r1.run_last = 1'b1;
		n_res  = 2'd0;
		held_d = held_q;
		exp_d  = exp_q;
		part_d = part_q;
		if (held_q == 2'd0) begin
			r0 = st_res;
			r0.run_last = 1'b1;
			if (st_emit) begin
				n_res = 2'd1;
			end else begin
				n_res  = 2'd1 - 2'd1;
				held_d = 2'd1;
				exp_d  = st_len;
				part_d = st_bits;
			end
		end else if (is_cont) begin
			if (cnt_inc >= exp_q) begin
				n_res = 2'd1;
				if (in_rng) begin
					r0.code_point = v_cat;
					r0.is_valid   = 1'b1;
				end
				held_d = 2'd0;
				exp_d  = '0;
				part_d = '0;
			end else if (stream.stream_end) begin
				n_res  = 2'd1;
				held_d = 2'd0;
				exp_d  = '0;
				part_d = '0;
			end else begin
				held_d = cnt_inc[1:0];
				part_d = v_cat;
			end
		end else begin
			// Broken sequence: flush the held bytes, then decode as a lead.
			r0.bytes_used = {1'b0, held_q};
			held_d = 2'd0;
			exp_d  = '0;
			part_d = '0;
			if (st_emit) begin
				n_res       = 2'd2;
				r0.run_last = 1'b0;
			end else begin
				n_res  = 2'd1;
				held_d = 2'd1;
				exp_d  = st_len;
				part_d = st_bits;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			exp_q  <= '0;
			part_q <= '0;
		end else if (accept) begin
			held_q <= held_d;
			exp_q  <= exp_d;
			part_q <= part_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
		end else if (accept) begin
			cnt_s1 <= n_res;
		end else if (out_fire) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res0_s1 <= r0;
			res1_s1 <= r1;
		end else if (out_fire) begin
			res0_s1 <= res1_s1;
		end
	end

	assign result.valid      = (cnt_s1 != 2'd0);
	assign result.code_point = res0_s1.code_point;
	assign result.is_valid   = res0_s1.is_valid;
	assign result.bytes_used = res0_s1.bytes_used;
	assign result.run_last   = res0_s1.run_last;

	// The result register never holds more than two results.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s1 != 2'd3)
		else $error("result register count out of range");

	// A lone result in the register is always the last one of its byte.
	a_lone_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s1 == 2'd1) |-> res0_s1.run_last)
		else $error("single pending result lacks run_last");

	// With two results pending, only the second one closes its byte.
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s1 == 2'd2) |-> (!res0_s1.run_last && res1_s1.run_last))
		else $error("run_last misplaced in result pair");

	// An open sequence always holds fewer bytes than its length.
	a_held_len: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != 2'd0) |-> ({1'b0, held_q} < exp_q))
		else $error("held bytes reach sequence length");

	// After one result of a pair leaves, the second one is still pending.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && cnt_s1 == 2'd2) |=> (cnt_s1 != 2'd0))
		else $error("second result of a pair was dropped");

endmodule

`default_nettype wire
